@@ rtl/bsa_pkg.sv @@
package bsa_pkg;

	localparam int DEF_SLOTS = 1024;
	localparam int WORD_BITS = 32;
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
	localparam int SLOT_W = 10;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOC   = 2'd0,
		ST_FULL    = 2'd1,
		ST_FREED   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_out;
	} rsp_t;

endpackage

@@ rtl/bsa_summary.sv @@
module bsa_summary
	import bsa_pkg::*;
#(
	parameter int WORDS = 32,
	parameter int WA = 5,
	parameter int EW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd_en,
	input  logic [WA-1:0] upd_word,
	input  logic          upd_full,
	input  logic [EW-1:0] word_lim,
	output logic          found,
	output logic [WA-1:0] first_word
);

	logic [WORDS-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd_en) begin
			full_q[upd_word] <= upd_full;
		end
	end

	always_comb begin
		found = 1'b0;
		first_word = '0;
		for (int w = WORDS - 1; w >= 0; w--) begin
			if (!full_q[w] && (EW'(w) < word_lim)) begin
				found = 1'b1;
				first_word = WA'(w);
			end
		end
	end

endmodule

@@ rtl/bsa_store.sv @@
module bsa_store
	import bsa_pkg::*;
#(
	parameter int WORD_W = 32,
	parameter int WORDS = 32,
	parameter int WA = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [WA-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [WA-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic              clearing
);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic [WA-1:0]     clr_addr_q;
	logic              clr_q;
	logic              we;
	logic [WA-1:0]     wa;
	logic [WORD_W-1:0] wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == WA'(WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = wr_en || clr_q;
		wa = clr_q ? clr_addr_q : wr_addr;
		wd = clr_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign clearing = clr_q;

endmodule

@@ rtl/bitmap_slot_allocator.sv @@
// An accepted request reads its bitmap word; in S_RMW the word is modified and
// written back and the response is registered. req_ready is low in S_RMW, so a
// new request waits for the read-modify-write of the bitmap word memory to end.
// Reset: asynchronous, active low; afterwards the bitmap is swept to zero one
// word per cycle with req_ready held low.
module bitmap_slot_allocator
	import bsa_pkg::*;
#(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp
);

	localparam int WORD_W = (SLOTS >= WORD_BITS) ? WORD_BITS : 8;
	localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
	localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW = $clog2(WORD_W);
	localparam int EW = (CFG_W > WA + BW + 1) ? CFG_W : WA + BW + 1;

	typedef enum logic {S_IDLE, S_RMW} state_t;

	typedef struct packed {
		logic              en;
		logic [WA-1:0]     addr;
		logic [WORD_W-1:0] data;
	} wr_t;

	state_t            state_q;
	logic [CFG_W-1:0]  active_q;
	logic [EW-1:0]     lim;
	logic [EW-1:0]     word_lim;
	logic [EW-1:0]     slot_ext;
	logic              found;
	logic [WA-1:0]     first_word;
	logic              clearing;
	logic              accept;
	logic [WA-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              op_s1;
	logic              found_s1;
	logic              inrange_s1;
	logic [WA-1:0]     word_s1;
	logic [BW-1:0]     fbit_s1;
	logic [BW-1:0]     zbit;
	logic [EW-1:0]     idx;
	wr_t               wr;
	rsp_t              rsp_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	always_comb begin
		lim = (EW'(active_q) < EW'(SLOTS)) ? EW'(active_q) : EW'(SLOTS);
		word_lim = EW'((lim + EW'(WORD_W - 1)) >> BW);
		slot_ext = EW'(req.slot_in);
		accept = req_valid && req_ready;
		rd_addr = (req.req_type == REQ_ALLOC) ? first_word : slot_ext[BW +: WA];
	end

	assign req_ready = (state_q == S_IDLE) && !clearing && (!rsp_valid_q || rsp_ready);

	bsa_summary #(.WORDS(WORDS), .WA(WA), .EW(EW)) u_summary (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_en     (wr.en),
		.upd_word   (wr.addr),
		.upd_full   (&wr.data),
		.word_lim   (word_lim),
		.found      (found),
		.first_word (first_word)
	);

	bsa_store #(.WORD_W(WORD_W), .WORDS(WORDS), .WA(WA)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr.en),
		.wr_addr  (wr.addr),
		.wr_data  (wr.data),
		.clearing (clearing)
	);

	always_comb begin
		zbit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!rd_data[b]) begin
				zbit = BW'(b);
			end
		end
	end

	always_comb begin
		idx = EW'({word_s1, zbit});
		wr.en = 1'b0;
		wr.addr = word_s1;
		wr.data = rd_data;
		rsp_d.status = ST_FULL;
		rsp_d.slot_out = '0;
		if (state_q == S_RMW) begin
			if (op_s1 == REQ_ALLOC) begin
				if (found_s1 && (idx < lim)) begin
					wr.en = 1'b1;
					wr.data[zbit] = 1'b1;
					rsp_d.status = ST_ALLOC;
					rsp_d.slot_out = idx[SLOT_W-1:0];
				end
			end else if (inrange_s1) begin
				wr.en = 1'b1;
				wr.data[fbit_s1] = 1'b0;
				rsp_d.status = ST_FREED;
			end else begin
				rsp_d.status = ST_IGNORED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= CFG_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (rsp_valid_q && rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= S_RMW;
					end
				end
				S_RMW: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.req_type;
			found_s1 <= found;
			inrange_s1 <= slot_ext < lim;
			word_s1 <= rd_addr;
			fbit_s1 <= slot_ext[BW-1:0];
		end
		if (state_q == S_RMW) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ rtl/bsa_checker.sv @@
module bsa_checker
	import bsa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted during read-modify-write");

	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("response missing two cycles after request");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_ALLOC |-> rsp.slot_out == '0)
		else $error("slot_out nonzero without allocation");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ bench/tb_top.sv @@
module tb_top
	import bsa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 20000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;

	bit [DEF_SLOTS-1:0] occupied;
	logic [CFG_W-1:0]   slot_count;
	rsp_t               outcomes_due[$];
	rsp_t               due;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 hold_left;
	int                 fault_count;
	int                 quiet_cycles;

	bitmap_slot_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	function automatic rsp_t predict_outcome(req_t r);
		rsp_t o;
		int   lim;
		bit   found;
		lim = (slot_count < DEF_SLOTS) ? int'(slot_count) : DEF_SLOTS;
		o.status = ST_FULL;
		o.slot_out = '0;
		if (r.req_type == REQ_ALLOC) begin
			found = 1'b0;
			for (int i = 0; i < lim && !found; i++) begin
				if (!occupied[i]) begin
					occupied[i] = 1'b1;
					o.status = ST_ALLOC;
					o.slot_out = SLOT_W'(i);
					found = 1'b1;
				end
			end
		end else if (int'(r.slot_in) < lim) begin
			occupied[r.slot_in] = 1'b0;
			o.status = ST_FREED;
		end else begin
			o.status = ST_IGNORED;
		end
		return o;
	endfunction

	task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot);
		req_t item;
		item.req_type = kind;
		item.slot_in = slot;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		outcomes_due.push_back(predict_outcome(item));
	endtask

	task automatic drain_outcomes();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_slot_count(input logic [CFG_W-1:0] value);
		drain_outcomes();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		slot_count = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_first_fit();
		repeat (4) send_request(REQ_ALLOC, SLOT_W'($urandom_range(1023)));
		send_request(REQ_FREE, 10'd1);
		send_request(REQ_FREE, 10'd1);
		send_request(REQ_ALLOC, 10'd1023);
		send_request(REQ_FREE, 10'd1023);
		send_request(REQ_FREE, 10'd0);
		send_request(REQ_ALLOC, 10'd0);
	endtask

	task automatic test_zero_count();
		set_slot_count('0);
		send_request(REQ_ALLOC, 10'd0);
		send_request(REQ_FREE, 10'd0);
		send_request(REQ_FREE, 10'd1023);
	endtask

	task automatic test_count_saturation();
		set_slot_count({CFG_W{1'b1}});
		send_request(REQ_ALLOC, 10'h2aa);
		send_request(REQ_FREE, 10'd1023);
		set_slot_count(11'd1025);
		send_request(REQ_ALLOC, 10'h155);
	endtask

	task automatic test_count_lowered();
		set_slot_count(11'd3);
		send_request(REQ_ALLOC, 10'd0);
		send_request(REQ_ALLOC, 10'd0);
		send_request(REQ_FREE, 10'd3);
		send_request(REQ_FREE, 10'd2);
		send_request(REQ_ALLOC, 10'd0);
		set_slot_count(11'd1024);
		send_request(REQ_FREE, 10'd3);
		send_request(REQ_ALLOC, 10'd0);
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct);
		int alloc_pct;
		int span;
		drain_outcomes();
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int c = 0; c < 6; c++) begin
			case (c)
				0: set_slot_count('0);
				1: set_slot_count(11'd1);
				2: set_slot_count(CFG_W'($urandom_range(48, 2)));
				3: set_slot_count({CFG_W{1'b1}});
				4: set_slot_count(11'd1024);
				default: set_slot_count(CFG_W'($urandom_range(2047)));
			endcase
			alloc_pct = $urandom_range(80, 30);
			span = (slot_count > 1020) ? 1023 : int'(slot_count) + 3;
			repeat (64) begin
				if ($urandom_range(99) < alloc_pct)
					send_request(REQ_ALLOC, SLOT_W'($urandom_range(1023)));
				else if ($urandom_range(9) < 7)
					send_request(REQ_FREE, SLOT_W'($urandom_range(span)));
				else
					send_request(REQ_FREE, SLOT_W'($urandom_range(1023)));
			end
		end
	endtask

	task automatic test_backpressure();
		drain_outcomes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_slot_count(11'd24);
		hold_left = 300;
		repeat (40) begin
			if ($urandom_range(1))
				send_request(REQ_ALLOC, SLOT_W'($urandom_range(1023)));
			else
				send_request(REQ_FREE, SLOT_W'($urandom_range(27)));
		end
		drain_outcomes();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (outcomes_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected response: status=%0d slot=%0d",
						rsp.status, rsp.slot_out);
			end else begin
				due = outcomes_due.pop_front();
				if (rsp.status !== due.status || rsp.slot_out !== due.slot_out) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: expected status=%0d slot=%0d, got status=%0d slot=%0d",
							due.status, due.slot_out, rsp.status, rsp.slot_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		hold_left = 0;
		fault_count = 0;
		quiet_cycles = 0;
		occupied = '0;
		slot_count = CFG_RESET;
		send_idle_pct = 27;
		recv_idle_pct = 67;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_fit();
		test_zero_count();
		test_count_saturation();
		test_count_lowered();
		test_random_traffic(27, 67);
		test_random_traffic(67, 27);
		test_random_traffic(0, 0);
		test_backpressure();

		drain_outcomes();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
